// ----- hw/rtl/chpp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// chpp_pkg: shared constants of the capacity hash probe placer
// Field widths, register map indexes, hash seed and parameter defaults.
// ----------------------------------------------------------------------------
package chpp_pkg;

    // parameter defaults
    localparam int          MAX_BINS_DEF     = 8;
    localparam logic [31:0] BIN_CAPACITY_DEF = 32'd163840;

    // hash multiplier for the block number
    localparam logic [31:0] HASH_SEED = 32'd174321;

    // field widths
    localparam int SIZE_W = 12;
    localparam int COST_W = 24;
    localparam int CAP_W  = 32;
    localparam int CNT_W  = 4;
    localparam int IDX_W  = 3;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // most negative capacity, the saturation floor
    localparam logic [CAP_W-1:0] CAP_MIN = 32'h8000_0000;

    // remainder divider: 29-bit hash padded to 30 bits, two bits per step
    localparam int QUO_W     = 30;
    localparam int DIV_STEPS = QUO_W / 2;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_DIRTY_MODE     = 2'd0;
    localparam logic [1:0] REG_INITIAL_ACTIVE = 2'd1;
    localparam logic [1:0] REG_TOTAL_BINS     = 2'd2;

endpackage
`default_nettype wire

// ----- hw/rtl/capacity_hash_probe_placer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// capacity_hash_probe_placer: hashed ring-probe placement of work blocks
// Computes a block's cost, hashes the block number to a starting bin, probes
// the bins in a ring for enough capacity, grows the active set or falls back
// to the roomiest bin, and subtracts the cost from the chosen bin.
// ----------------------------------------------------------------------------
// A block is taken when start is high and busy is low; busy then stays high
// until the result beat, which is shown for exactly one cycle with done high
// and must be captured then, since the receiver cannot stall it. A block
// runs through the cost multiply, a 15-step remainder divider that resolves
// two bits of the hashed block number per cycle, a registered read of the
// starting bin from the single port of the capacity memory, a compare and
// the write-back; each extra bin probed adds a registered memory read, a
// roomiest-bin update and a compare. On a fallback, the refetch of the
// roomiest bin takes the place of the final compare.
module capacity_hash_probe_placer #(
    parameter int          MAX_BINS     = chpp_pkg::MAX_BINS_DEF,
    parameter logic [31:0] BIN_CAPACITY = chpp_pkg::BIN_CAPACITY_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // command channel
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [chpp_pkg::SIZE_W-1:0]      left_size,
    input  wire logic [chpp_pkg::SIZE_W-1:0]      right_size,
    // result channel
    output logic                                  done,
    output logic [chpp_pkg::IDX_W-1:0]            bin_index,
    output logic [chpp_pkg::COST_W-1:0]           block_cost,
    output logic signed [chpp_pkg::CAP_W-1:0]     remaining_capacity,
    output logic [chpp_pkg::CNT_W-1:0]            active_bins,
    output logic                                  fell_back,
    // configuration port
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [chpp_pkg::ADDR_W-1:0]      paddr,
    input  wire logic [chpp_pkg::DATA_W-1:0]      pwdata,
    output logic [chpp_pkg::DATA_W-1:0]           prdata,
    output logic                                  pready
);

    localparam int BW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int SW = chpp_pkg::SIZE_W;
    localparam int KW = chpp_pkg::COST_W;
    localparam int CW = chpp_pkg::CAP_W;
    localparam int NW = chpp_pkg::CNT_W;
    localparam int QW = chpp_pkg::QUO_W;
    localparam logic [7:0] MAX_BINS_8 = 8'(MAX_BINS);

    // sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_COST    = 3'd1;
    localparam logic [2:0] S_DIV     = 3'd2;
    localparam logic [2:0] S_FETCH   = 3'd3;
    localparam logic [2:0] S_TEST    = 3'd4;
    localparam logic [2:0] S_FETCH2  = 3'd5;
    localparam logic [2:0] S_UPDATE  = 3'd6;
    localparam logic [2:0] S_WRITE   = 3'd7;

    // configuration registers
    logic          dirty_mode_reg;
    logic [NW-1:0] initial_active_reg;
    logic [NW-1:0] total_bins_reg;

    // control state
    logic [2:0]    state_reg, state_next;
    logic [31:0]   block_counter_reg, block_counter_next;
    logic [NW-1:0] bins_added_reg, bins_added_next;
    logic [NW-1:0] active_reg, active_next;
    logic [NW-1:0] total_reg, total_next;
    logic [NW:0]   count_reg, count_next;
    logic [BW-1:0] bin_reg, bin_next;
    logic [BW-1:0] max_bin_reg, max_bin_next;
    logic          have_max_reg, have_max_next;
    logic          fell_reg, fell_next;
    logic          fb_reg, fb_next;
    logic [3:0]    step_reg, step_next;
    logic          done_reg, done_next;

    // datapath registers
    logic [SW-1:0] left_reg, left_next;
    logic [SW-1:0] right_reg, right_next;
    logic [KW-1:0] cost_reg, cost_next;
    logic [QW-1:0] dq_reg, dq_next;
    logic [3:0]    rem_reg, rem_next;
    logic [CW-1:0] max_cap_reg, max_cap_next;
    logic [2:0]    out_bin_reg, out_bin_next;
    logic [CW-1:0] out_rem_reg, out_rem_next;

    // capacity memory
    logic [CW-1:0]       cap_mem [MAX_BINS];
    logic [MAX_BINS-1:0] valid_reg;
    logic [CW-1:0]       rd_data_reg;
    logic                rd_valid_reg;
    logic                mem_we;
    logic [CW-1:0]       wr_data;

    // combinational helpers
    logic [SW-1:0] sel_size;
    logic [KW-1:0] cost_prod;
    logic [31:0]   hash_prod;
    logic [NW-1:0] tot_c, ini_c, act_c;
    logic [4:0]    r1, r2;
    logic [4:0]    r1s, r2s;
    logic [7:0]    start_8;
    logic [CW-1:0] cap_eff;
    logic [7:0]    bin_inc_8;
    logic [BW-1:0] bin_wrap;
    logic          take_max;
    logic          nh;
    logic [CW-1:0] nmax;
    logic [BW-1:0] nbin;
    logic [CW:0]   sub_33;

    assign busy               = (state_reg != S_IDLE);
    assign done               = done_reg;
    assign bin_index          = out_bin_reg;
    assign block_cost         = cost_reg;
    assign remaining_capacity = out_rem_reg;
    assign active_bins        = active_reg;
    assign fell_back          = fell_reg;
    assign pready             = 1'b1;

    // register read-back
    always_comb
    begin
        case (paddr[3:2])
            chpp_pkg::REG_DIRTY_MODE:     prdata = {31'd0, dirty_mode_reg};
            chpp_pkg::REG_INITIAL_ACTIVE: prdata = {28'd0, initial_active_reg};
            chpp_pkg::REG_TOTAL_BINS:     prdata = {28'd0, total_bins_reg};
            default:                      prdata = '0;
        endcase
    end

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dirty_mode_reg     <= 1'b0;
            initial_active_reg <= 4'd1;
            total_bins_reg     <= 4'd8;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[3:2])
                chpp_pkg::REG_DIRTY_MODE:     dirty_mode_reg     <= pwdata[0];
                chpp_pkg::REG_INITIAL_ACTIVE: initial_active_reg <= pwdata[3:0];
                chpp_pkg::REG_TOTAL_BINS:     total_bins_reg     <= pwdata[3:0];
                default:                      ;
            endcase
        end
    end

    // cost and hash products
    assign sel_size  = (dirty_mode_reg || (left_reg > right_reg)) ? left_reg : right_reg;
    assign cost_prod = sel_size * sel_size;
    assign hash_prod = block_counter_reg * chpp_pkg::HASH_SEED;

    // effective total and active counts
    always_comb
    begin
        if (total_bins_reg == 4'd0)
            tot_c = 4'd1;
        else if ({4'd0, total_bins_reg} > MAX_BINS_8)
            tot_c = MAX_BINS_8[NW-1:0];
        else
            tot_c = total_bins_reg;
        if (initial_active_reg == 4'd0)
            ini_c = 4'd1;
        else if (initial_active_reg > tot_c)
            ini_c = tot_c;
        else
            ini_c = initial_active_reg;
        if (bins_added_reg >= (tot_c - ini_c))
            act_c = tot_c;
        else
            act_c = ini_c + bins_added_reg;
    end

    // two restoring remainder steps per cycle
    always_comb
    begin
        r1  = {rem_reg, dq_reg[QW-1]};
        r1s = (r1 >= {1'b0, active_reg}) ? (r1 - {1'b0, active_reg}) : r1;
        r2  = {r1s[3:0], dq_reg[QW-2]};
        r2s = (r2 >= {1'b0, active_reg}) ? (r2 - {1'b0, active_reg}) : r2;
        start_8 = {4'd0, r2s[3:0]};
    end

    // probe helpers
    assign cap_eff   = rd_valid_reg ? BIN_CAPACITY : rd_data_reg;
    assign bin_inc_8 = 8'(bin_reg) + 8'd1;
    assign bin_wrap  = (bin_inc_8 == {4'd0, active_reg}) ? '0 : bin_inc_8[BW-1:0];
    assign take_max  = (!have_max_reg || ($signed(max_cap_reg) < $signed(cap_eff)))
                       && ((cap_eff != chpp_pkg::CAP_MIN) || have_max_reg);
    assign nh        = have_max_reg || take_max;
    assign nmax      = take_max ? cap_eff : max_cap_reg;
    assign nbin      = take_max ? bin_reg : max_bin_reg;

    // saturating subtraction of the cost
    assign sub_33  = {cap_eff[CW-1], cap_eff} - {9'd0, cost_reg};
    assign wr_data = (sub_33[CW] && !sub_33[CW-1]) ? chpp_pkg::CAP_MIN : sub_33[CW-1:0];
    assign mem_we  = (state_reg == S_WRITE);

    // sequencer
    always_comb
    begin
        state_next         = state_reg;
        block_counter_next = block_counter_reg;
        bins_added_next    = bins_added_reg;
        active_next        = active_reg;
        total_next         = total_reg;
        count_next         = count_reg;
        bin_next           = bin_reg;
        max_bin_next       = max_bin_reg;
        have_max_next      = have_max_reg;
        fell_next          = fell_reg;
        fb_next            = fb_reg;
        step_next          = step_reg;
        done_next          = 1'b0;
        left_next          = left_reg;
        right_next         = right_reg;
        cost_next          = cost_reg;
        dq_next            = dq_reg;
        rem_next           = rem_reg;
        max_cap_next       = max_cap_reg;
        out_bin_next       = out_bin_reg;
        out_rem_next       = out_rem_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    left_next   = left_size;
                    right_next  = right_size;
                    total_next  = tot_c;
                    active_next = act_c;
                    dq_next     = {1'b0, hash_prod[31:3]};
                    rem_next    = 4'd0;
                    step_next   = 4'd0;
                    state_next  = S_COST;
                end
            end
            S_COST:
            begin
                cost_next  = cost_prod;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                dq_next   = {dq_reg[QW-3:0], 2'b00};
                rem_next  = r2s[3:0];
                step_next = step_reg + 4'd1;
                if (step_reg == 4'(chpp_pkg::DIV_STEPS - 1))
                begin
                    bin_next      = start_8[BW-1:0];
                    max_bin_next  = start_8[BW-1:0];
                    have_max_next = 1'b0;
                    count_next    = '0;
                    fell_next     = 1'b0;
                    fb_next       = 1'b0;
                    state_next    = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = fb_reg ? S_WRITE : S_TEST;
            end
            S_TEST:
            begin
                if ($signed(cap_eff) < $signed({8'd0, cost_reg}))
                begin
                    bin_next   = bin_wrap;
                    count_next = count_reg + 5'd1;
                    state_next = S_FETCH2;
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end
            S_FETCH2:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                have_max_next = nh;
                max_cap_next  = nmax;
                max_bin_next  = nbin;
                state_next    = S_TEST;
                if (count_reg > {1'b0, active_reg})
                begin
                    if (nh && ($signed(nmax) > 0) && (active_reg < total_reg))
                    begin
                        active_next     = active_reg + 4'd1;
                        bins_added_next = bins_added_reg + 4'd1;
                    end
                    else
                    begin
                        bin_next   = nbin;
                        fell_next  = 1'b1;
                        fb_next    = 1'b1;
                        state_next = S_FETCH;
                    end
                end
            end
            S_WRITE:
            begin
                out_bin_next       = 8'(bin_reg) > 8'd0 ? 3'(8'(bin_reg)) : 3'd0;
                out_rem_next       = wr_data;
                block_counter_next = block_counter_reg + 32'd1;
                done_next          = 1'b1;
                state_next         = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            block_counter_reg <= '0;
            bins_added_reg    <= '0;
            active_reg        <= 4'd1;
            total_reg         <= 4'd1;
            count_reg         <= '0;
            bin_reg           <= '0;
            max_bin_reg       <= '0;
            have_max_reg      <= 1'b0;
            fell_reg          <= 1'b0;
            fb_reg            <= 1'b0;
            step_reg          <= '0;
            done_reg          <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            block_counter_reg <= block_counter_next;
            bins_added_reg    <= bins_added_next;
            active_reg        <= active_next;
            total_reg         <= total_next;
            count_reg         <= count_next;
            bin_reg           <= bin_next;
            max_bin_reg       <= max_bin_next;
            have_max_reg      <= have_max_next;
            fell_reg          <= fell_next;
            fb_reg            <= fb_next;
            step_reg          <= step_next;
            done_reg          <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        left_reg    <= left_next;
        right_reg   <= right_next;
        cost_reg    <= cost_next;
        dq_reg      <= dq_next;
        rem_reg     <= rem_next;
        max_cap_reg <= max_cap_next;
        out_bin_reg <= out_bin_next;
        out_rem_reg <= out_rem_next;
    end

    // capacity memory, one port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            cap_mem[bin_reg] <= wr_data;
        rd_data_reg  <= cap_mem[bin_reg];
        rd_valid_reg <= !valid_reg[bin_reg];
    end

    // written marks, an unwritten bin reads as full capacity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (mem_we)
            valid_reg[bin_reg] <= 1'b1;
    end

`ifndef SYNTHESIS
    // result beat only once the sequencer is back at rest
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result beat while busy");

    // an accepted block makes the block busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted block did not start");

    // divider remainder stays below the divisor
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < active_reg))
        else $error("remainder out of range");

    // probed bin stays inside the active ring
    a_bin_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_TEST) || (state_reg == S_UPDATE) || (state_reg == S_WRITE))
        |-> (8'(bin_reg) < {4'd0, active_reg}))
        else $error("bin outside active set");

    // active count never passes the total
    a_active_total: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg != S_IDLE) && (state_reg != S_COST))
        |-> (active_reg <= total_reg) && (active_reg != 4'd0))
        else $error("active count out of range");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/tb_capacity_hash_probe_placer.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_capacity_hash_probe_placer: self-checking bench for the bin placer
// Drives work blocks on the start/busy command port and register writes on
// the APB port, predicts every placement with a local model of the cost,
// hash, ring probe, growth and fallback rules, and checks each done beat
// field by field. A directed table runs first, then randomized phases.
// ----------------------------------------------------------------------------
module tb_capacity_hash_probe_placer;

    localparam int          NUM_BINS    = chpp_pkg::MAX_BINS_DEF;
    localparam longint      CAP_FLOOR   = -64'sd2147483648;
    localparam int          STALL_LIMIT = 4000;
    localparam int          TAIL_CYCLES = 100;
    localparam int          PRINT_LIMIT = 40;
    localparam logic [1:0]  REG_UNMAPPED = 2'd3;

    // one placement as reported on the result ports
    typedef struct packed {
        logic [chpp_pkg::IDX_W-1:0]        bin_idx;
        logic [chpp_pkg::COST_W-1:0]       cost;
        logic signed [chpp_pkg::CAP_W-1:0] rem;
        logic [chpp_pkg::CNT_W-1:0]        active;
        logic                              fell;
    } placement_t;

    typedef enum logic { ROW_BLOCK, ROW_REG } row_kind_t;
    typedef enum logic { MIX_LIGHT, MIX_HEAVY } size_mix_t;

    // one row of the directed table
    typedef struct packed {
        row_kind_t                   kind;
        logic [1:0]                  reg_idx;
        logic [31:0]                 reg_val;
        logic [chpp_pkg::SIZE_W-1:0] left;
        logic [chpp_pkg::SIZE_W-1:0] right;
        logic                        typed;
        placement_t                  want;
    } stim_row_t;

    logic                              clk;
    logic                              rst_n;
    logic                              start;
    logic                              busy;
    logic [chpp_pkg::SIZE_W-1:0]       left_size;
    logic [chpp_pkg::SIZE_W-1:0]       right_size;
    logic                              done;
    logic [chpp_pkg::IDX_W-1:0]        bin_index;
    logic [chpp_pkg::COST_W-1:0]       block_cost;
    logic signed [chpp_pkg::CAP_W-1:0] remaining_capacity;
    logic [chpp_pkg::CNT_W-1:0]        active_bins;
    logic                              fell_back;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [chpp_pkg::ADDR_W-1:0]       paddr;
    logic [chpp_pkg::DATA_W-1:0]       pwdata;
    logic [chpp_pkg::DATA_W-1:0]       prdata;
    logic                              pready;

    // mirror of the block state and registers
    logic signed [chpp_pkg::CAP_W-1:0] cap_mirror [NUM_BINS];
    logic [31:0]                       block_seq;
    logic [chpp_pkg::CNT_W-1:0]        grown_bins;
    logic                              cfg_dirty;
    logic [chpp_pkg::CNT_W-1:0]        cfg_initial;
    logic [chpp_pkg::CNT_W-1:0]        cfg_total;

    placement_t expected_placements [$];
    stim_row_t  directed_rows [$];
    placement_t mon_got;
    placement_t mon_want;
    int         mismatch_count;
    int         result_count;
    int         stall_cycles;

    capacity_hash_probe_placer dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .left_size          (left_size),
        .right_size         (right_size),
        .done               (done),
        .bin_index          (bin_index),
        .block_cost         (block_cost),
        .remaining_capacity (remaining_capacity),
        .active_bins        (active_bins),
        .fell_back          (fell_back),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string text);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("MISMATCH @%0t: %s", $time, text);
    endtask

    // placement predictor: cost, hashed start, ring probe, growth, fallback
    function automatic placement_t place_block(input logic [chpp_pkg::SIZE_W-1:0] l,
                                               input logic [chpp_pkg::SIZE_W-1:0] r);
        int unsigned lw;
        int unsigned rw;
        int unsigned total;
        int unsigned active;
        int unsigned first;
        int unsigned bin;
        int unsigned probes;
        int unsigned best_bin;
        int unsigned cost;
        logic [31:0] hash;
        longint      best_cap;
        longint      cap_now;
        longint      rem;
        bit          have_best;
        bit          fell;
        bit          searching;
        placement_t  res;
        lw = l;
        rw = r;
        total = cfg_total;
        if (total < 1) total = 1;
        if (total > NUM_BINS) total = NUM_BINS;
        active = cfg_initial;
        if (active < 1) active = 1;
        if (active > total) active = total;
        if (grown_bins >= total - active) active = total;
        else active = active + grown_bins;

        cost = (cfg_dirty || lw > rw) ? lw * lw : rw * rw;
        hash = block_seq * chpp_pkg::HASH_SEED;
        first = (hash >> 3) % active;
        bin = first;
        best_bin = first;
        best_cap = CAP_FLOOR;
        have_best = 1'b0;
        fell = 1'b0;
        probes = 0;
        cap_now = cap_mirror[bin];
        searching = cap_now < longint'(cost);

        // walk the ring; the active count may grow while probing
        while (searching)
        begin
            bin = (bin + 1) % active;
            probes++;
            cap_now = cap_mirror[bin];
            if ((!have_best || best_cap < cap_now) && (cap_now > CAP_FLOOR || have_best))
            begin
                best_bin = bin;
                best_cap = cap_now;
                have_best = 1'b1;
            end
            if (probes > active)
            begin
                if (have_best && best_cap > 0 && active < total)
                begin
                    grown_bins++;
                    active++;
                end
                else
                begin
                    bin = best_bin;
                    fell = 1'b1;
                    searching = 1'b0;
                end
            end
            if (searching)
            begin
                cap_now = cap_mirror[bin];
                searching = cap_now < longint'(cost);
            end
        end

        // subtract with saturation at the floor
        cap_now = cap_mirror[bin];
        rem = cap_now - longint'(cost);
        if (rem < CAP_FLOOR) rem = CAP_FLOOR;
        cap_mirror[bin] = rem[31:0];
        block_seq++;

        res.bin_idx = bin[chpp_pkg::IDX_W-1:0];
        res.cost = cost[chpp_pkg::COST_W-1:0];
        res.rem = rem[31:0];
        res.active = active[chpp_pkg::CNT_W-1:0];
        res.fell = fell;
        return res;
    endfunction

    function automatic logic [chpp_pkg::SIZE_W-1:0] pick_size();
        int unsigned sel;
        sel = $urandom_range(0, 15);
        if (sel == 0) return 12'($urandom_range(0, 4095));
        if (sel == 1) return ($urandom_range(0, 1) == 1) ? 12'hFFF : 12'h000;
        return 12'($urandom_range(0, 63));
    endfunction

    function automatic void add_row(input row_kind_t kind, input logic [1:0] idx,
                                    input logic [31:0] val,
                                    input logic [chpp_pkg::SIZE_W-1:0] l,
                                    input logic [chpp_pkg::SIZE_W-1:0] r,
                                    input logic typed, input placement_t want);
        stim_row_t row;
        row.kind = kind;
        row.reg_idx = idx;
        row.reg_val = val;
        row.left = l;
        row.right = r;
        row.typed = typed;
        row.want = want;
        directed_rows = {directed_rows, row};
    endfunction

    // sender stops and waits until every placement is back
    task automatic drain_results();
        start = 1'b0;
        while (expected_placements.size() != 0 || busy)
            @(negedge clk);
    endtask

    // one command beat; start is left high for a back-to-back follower
    task automatic send_block(input logic [chpp_pkg::SIZE_W-1:0] l,
                              input logic [chpp_pkg::SIZE_W-1:0] r,
                              input logic typed, input placement_t want);
        placement_t pred;
        start = 1'b1;
        left_size = l;
        right_size = r;
        do
            @(posedge clk);
        while (busy);
        pred = place_block(l, r);
        if (typed)
            pred = want;
        expected_placements = {expected_placements, pred};
        @(negedge clk);
    endtask

    // random sender idling and occasional full drain
    task automatic pause_sender(input bit allow);
        if (allow && $urandom_range(0, 3) == 0)
        begin
            start = 1'b0;
            if ($urandom_range(0, 1) == 1)
                while (busy) @(negedge clk);
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        if (allow && $urandom_range(0, 63) == 0)
            drain_results();
    endtask

    task automatic apb_transfer(input bit is_write, input logic [chpp_pkg::ADDR_W-1:0] addr,
                                input logic [chpp_pkg::DATA_W-1:0] wdata,
                                output logic [chpp_pkg::DATA_W-1:0] rdata);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = is_write;
        paddr = addr;
        pwdata = wdata;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // register write while idle, then read back unless the slot is unmapped
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        logic [chpp_pkg::DATA_W-1:0] mask;
        logic [chpp_pkg::DATA_W-1:0] wdata;
        logic [chpp_pkg::DATA_W-1:0] readback;
        logic [chpp_pkg::ADDR_W-1:0] addr;
        drain_results();
        mask = (idx == chpp_pkg::REG_DIRTY_MODE) ? 32'h1 : 32'hF;
        wdata = ($urandom & ~mask) | (val & mask);
        addr = {idx, 2'b00};
        apb_transfer(1'b1, addr, wdata, readback);
        case (idx)
            chpp_pkg::REG_DIRTY_MODE:     cfg_dirty = wdata[0];
            chpp_pkg::REG_INITIAL_ACTIVE: cfg_initial = wdata[chpp_pkg::CNT_W-1:0];
            chpp_pkg::REG_TOTAL_BINS:     cfg_total = wdata[chpp_pkg::CNT_W-1:0];
            default: ;
        endcase
        if (idx != REG_UNMAPPED)
        begin
            apb_transfer(1'b0, addr, $urandom, readback);
            if (readback !== (wdata & mask))
                report_mismatch($sformatf("register %0d read 0x%0h, wrote 0x%0h",
                                          idx, readback, wdata & mask));
        end
    endtask

    task automatic run_phase(input logic dirty, input logic [3:0] init_bins,
                             input logic [3:0] total_bins, input int count,
                             input size_mix_t mix, input bit idle_ok);
        logic [chpp_pkg::SIZE_W-1:0] l;
        logic [chpp_pkg::SIZE_W-1:0] r;
        write_reg(chpp_pkg::REG_DIRTY_MODE, {31'd0, dirty});
        write_reg(chpp_pkg::REG_INITIAL_ACTIVE, {28'd0, init_bins});
        write_reg(chpp_pkg::REG_TOTAL_BINS, {28'd0, total_bins});
        for (int i = 0; i < count; i++)
        begin
            if (mix == MIX_HEAVY)
            begin
                l = ($urandom_range(0, 7) != 0) ? 12'hFFF : pick_size();
                r = 12'($urandom_range(0, 4095));
            end
            else
            begin
                l = pick_size();
                r = pick_size();
            end
            send_block(l, r, 1'b0, '0);
            pause_sender(idle_ok);
        end
    endtask

    task automatic check_placement(input placement_t got, input placement_t want);
        if (got.bin_idx !== want.bin_idx)
            report_mismatch($sformatf("result %0d bin_index %0d, want %0d",
                                      result_count, got.bin_idx, want.bin_idx));
        if (got.cost !== want.cost)
            report_mismatch($sformatf("result %0d block_cost %0d, want %0d",
                                      result_count, got.cost, want.cost));
        if (got.rem !== want.rem)
            report_mismatch($sformatf("result %0d remaining_capacity %0d, want %0d",
                                      result_count, got.rem, want.rem));
        if (got.active !== want.active)
            report_mismatch($sformatf("result %0d active_bins %0d, want %0d",
                                      result_count, got.active, want.active));
        if (got.fell !== want.fell)
            report_mismatch($sformatf("result %0d fell_back %0d, want %0d",
                                      result_count, got.fell, want.fell));
    endtask

    // result beat checker and stall watchdog
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            mon_got.bin_idx = bin_index;
            mon_got.cost = block_cost;
            mon_got.rem = remaining_capacity;
            mon_got.active = active_bins;
            mon_got.fell = fell_back;
            if (expected_placements.size() == 0)
                report_mismatch($sformatf("result beat with nothing expected, bin %0d",
                                          bin_index));
            else
            begin
                mon_want = expected_placements.pop_front();
                check_placement(mon_got, mon_want);
            end
            result_count++;
        end
        if ((start && !busy) || done)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // main sequence
    initial
    begin
        placement_t first_want;
        rst_n = 1'b0;
        start = 1'b0;
        left_size = '0;
        right_size = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatch_count = 0;
        result_count = 0;
        stall_cycles = 0;
        cfg_dirty = 1'b0;
        cfg_initial = 4'd1;
        cfg_total = 4'd8;
        block_seq = '0;
        grown_bins = '0;
        for (int i = 0; i < NUM_BINS; i++)
            cap_mirror[i] = chpp_pkg::BIN_CAPACITY_DEF;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        first_want.bin_idx = '0;
        first_want.cost = '0;
        first_want.rem = chpp_pkg::BIN_CAPACITY_DEF;
        first_want.active = 4'd1;
        first_want.fell = 1'b0;
        // empty block right after reset lands in bin 0 untouched
        add_row(ROW_BLOCK, 2'd0, 0, 12'd0, 12'd0, 1'b1, first_want);
        add_row(ROW_REG, chpp_pkg::REG_TOTAL_BINS, 2, 12'd0, 12'd0, 1'b0, '0);
        // nearly fill bin 0, then a block that grows a bin and falls back with room
        add_row(ROW_BLOCK, 2'd0, 0, 12'd400, 12'd0, 1'b0, '0);
        add_row(ROW_BLOCK, 2'd0, 0, 12'd100, 12'd0, 1'b0, '0);
        // largest costs, either side larger
        add_row(ROW_BLOCK, 2'd0, 0, 12'd4095, 12'd4095, 1'b0, '0);
        add_row(ROW_BLOCK, 2'd0, 0, 12'd4095, 12'd0, 1'b0, '0);
        add_row(ROW_BLOCK, 2'd0, 0, 12'd0, 12'd4095, 1'b0, '0);
        // dirty mode ignores the right side
        add_row(ROW_REG, chpp_pkg::REG_DIRTY_MODE, 1, 12'd0, 12'd0, 1'b0, '0);
        add_row(ROW_BLOCK, 2'd0, 0, 12'd4095, 12'd0, 1'b0, '0);
        add_row(ROW_BLOCK, 2'd0, 0, 12'd0, 12'd4095, 1'b0, '0);
        add_row(ROW_BLOCK, 2'd0, 0, 12'd1, 12'd4095, 1'b0, '0);
        add_row(ROW_REG, chpp_pkg::REG_DIRTY_MODE, 0, 12'd0, 12'd0, 1'b0, '0);
        add_row(ROW_BLOCK, 2'd0, 0, 12'd4094, 12'd4095, 1'b0, '0);
        add_row(ROW_BLOCK, 2'd0, 0, 12'd4095, 12'd4094, 1'b0, '0);
        add_row(ROW_BLOCK, 2'd0, 0, 12'd2, 12'd1, 1'b0, '0);
        add_row(ROW_BLOCK, 2'd0, 0, 12'd1, 12'd2, 1'b0, '0);
        add_row(ROW_BLOCK, 2'd0, 0, 12'd7, 12'd7, 1'b0, '0);
        // out of range registers are clamped
        add_row(ROW_REG, chpp_pkg::REG_TOTAL_BINS, 0, 12'd0, 12'd0, 1'b0, '0);
        add_row(ROW_BLOCK, 2'd0, 0, 12'd5, 12'd9, 1'b0, '0);
        add_row(ROW_REG, chpp_pkg::REG_INITIAL_ACTIVE, 0, 12'd0, 12'd0, 1'b0, '0);
        add_row(ROW_REG, chpp_pkg::REG_TOTAL_BINS, 15, 12'd0, 12'd0, 1'b0, '0);
        add_row(ROW_BLOCK, 2'd0, 0, 12'd9, 12'd5, 1'b0, '0);
        add_row(ROW_REG, chpp_pkg::REG_INITIAL_ACTIVE, 15, 12'd0, 12'd0, 1'b0, '0);
        add_row(ROW_BLOCK, 2'd0, 0, 12'hAAA, 12'h555, 1'b0, '0);
        add_row(ROW_BLOCK, 2'd0, 0, 12'h555, 12'hAAA, 1'b0, '0);
        // write to an unmapped slot changes nothing
        add_row(ROW_REG, REG_UNMAPPED, 5, 12'd0, 12'd0, 1'b0, '0);
        add_row(ROW_BLOCK, 2'd0, 0, 12'd63, 12'd0, 1'b0, '0);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_REG)
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            else
            begin
                send_block(directed_rows[i].left, directed_rows[i].right,
                           directed_rows[i].typed, directed_rows[i].want);
                pause_sender(1'b1);
            end
        end

        // random phases: gradual growth, dirty mode, all bins active,
        // saturation of bins 0 and 1, blocks with no roomiest bin, then a run with no idling
        run_phase(1'b0, 4'd1, 4'd8, 500, MIX_LIGHT, 1'b1);
        run_phase(1'b1, 4'd3, 4'd6, 300, MIX_LIGHT, 1'b1);
        run_phase(1'b0, 4'd8, 4'd8, 250, MIX_LIGHT, 1'b1);
        run_phase(1'b1, 4'd1, 4'd1, 150, MIX_HEAVY, 1'b1);
        run_phase(1'b1, 4'd2, 4'd2, 150, MIX_HEAVY, 1'b1);
        run_phase(1'b0, 4'd2, 4'd2, 80, MIX_LIGHT, 1'b1);
        run_phase(1'b0, 4'd1, 4'd8, 450, MIX_LIGHT, 1'b0);

        // wait out the last results and a quiet tail
        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (expected_placements.size() != 0)
            report_mismatch($sformatf("%0d placements never reported",
                                      expected_placements.size()));
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- capacity_hash_probe_placer.f -----
hw/rtl/chpp_pkg.sv
hw/rtl/capacity_hash_probe_placer.sv
tb/sv/tb_capacity_hash_probe_placer.sv
